### src/ckr_pkg.sv
// Shared types, constants and the keyword table of the keyword recognizer.
`timescale 1ns / 1ps

package ckr_pkg;

  localparam int KEYWORD_COUNT = 37;
  localparam int MAX_KEY_LEN   = 8;
  localparam int HASH_MODULUS  = 77;

  localparam int KW_TABLE_SIZE = 37;
  localparam int KW_TEXT_MAX   = 8;
  localparam int INDEX_W       = 6;
  localparam int BUCKET_W      = 7;
  localparam logic [INDEX_W-1:0] SPACE_CODE = 6'd32;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic                is_keyword;
    logic [INDEX_W-1:0]  keyword_index;
    logic                replace_first;
    logic [BUCKET_W-1:0] hash_bucket;
  } out_t;

  // Text of table slot k (index k + 1), right-justified: the first character
  // sits in the highest used byte.
  function automatic logic [8*KW_TEXT_MAX-1:0] kw_text(input int k);
    logic [8*KW_TEXT_MAX-1:0] t;
    case (k)
      0:  t = "#define";
      1:  t = "#include";
      2:  t = "break";
      3:  t = "case";
      4:  t = "char";
      5:  t = "continue";
      6:  t = "default";
      7:  t = "double";
      8:  t = "\t";
      9:  t = "\n";
      10: t = "else";
      11: t = "enum";
      12: t = "extern";
      13: t = "float";
      14: t = "for";
      15: t = "goto";
      16: t = "if";
      17: t = "int";
      18: t = "long";
      19: t = "register";
      20: t = "return";
      21: t = "short";
      22: t = "sizeof";
      23: t = "static";
      24: t = "struct";
      25: t = "switch";
      26: t = "typedef";
      27: t = "union";
      28: t = "unsigned";
      29: t = "void";
      30: t = "while";
      31: t = "do";
      32: t = "auto";
      33: t = "fortran";
      34: t = "const";
      35: t = "signed";
      36: t = "volatile";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic int kw_len(input int k);
    int n;
    case (k)
      8, 9:                          n = 1;
      16, 31:                        n = 2;
      14, 17:                        n = 3;
      3, 4, 10, 11, 15, 18, 29, 32:  n = 4;
      2, 13, 21, 27, 30, 34:         n = 5;
      7, 12, 20, 22, 23, 24, 25, 35: n = 6;
      0, 6, 26, 33:                  n = 7;
      1, 5, 19, 28, 36:              n = 8;
      default:                       n = 0;
    endcase
    return n;
  endfunction

endpackage

### src/ckr_match.sv
// Parallel compare of the collected identifier against the keyword table.
`timescale 1ns / 1ps

module ckr_match
  import ckr_pkg::*;
#(
  parameter int KEYWORD_COUNT = ckr_pkg::KEYWORD_COUNT,
  parameter int MAX_KEY_LEN   = ckr_pkg::MAX_KEY_LEN,
  parameter int POS_W         = $clog2(MAX_KEY_LEN + 2)
) (
  input  logic [7:0]         text [MAX_KEY_LEN],
  input  logic [POS_W-1:0]   text_len,
  output logic [INDEX_W-1:0] match_index
);

  localparam int ENTRIES = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

  logic [INDEX_W-1:0] hit_index [ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    localparam int                       L = kw_len(k);
    localparam logic [8*KW_TEXT_MAX-1:0] T = kw_text(k);
    logic hit;

    if (L > MAX_KEY_LEN) begin : g_too_long
      assign hit = 1'b0;
    end else begin : g_cmp
      logic [L-1:0] byte_eq;
      for (genvar j = 0; j < L; j++) begin : g_byte
        assign byte_eq[j] = (text[j] == T[8*(L-1-j) +: 8]);
      end
      assign hit = (text_len == POS_W'(L)) && (&byte_eq);
    end

    // Entries are distinct, so at most one hit; indices can be OR-ed.
    assign hit_index[k] = hit ? INDEX_W'(k + 1) : '0;
  end

  always_comb begin
    match_index = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      match_index = match_index | hit_index[k];
    end
  end

endmodule

### src/c_keyword_recognizer.sv
// Keyword recognizer: collects identifier bytes, reports keyword match and hash.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one identifier byte per
//   request; in_data.last_char marks the final byte. Each final byte yields one
//   result on the output channel (out_valid / out_stall / out_data): match flag,
//   table index, compression flag and byte-sum hash bucket.
//   The result is registered and shows in the cycle after the final byte is accepted.
//   Throughput: one byte per cycle unless a held result stalls, back to back,
//   including the final byte of one identifier and the first of the next.
//   The per-byte work is one pass through the table compare and a one-step
//   modular add between the identifier state and the result register.
//   If the receiver stalls while a result is held, in_stall rises and stays
//   high until the result is taken; the held result does not change.
//   cfg_we / cfg_data write compress_enable; write only while idle.
//   Reset (rst, synchronous) clears the identifier position and bucket, the
//   result valid flag and compress_enable; text and result data are not reset.
`timescale 1ns / 1ps

module c_keyword_recognizer
  import ckr_pkg::*;
#(
  parameter int KEYWORD_COUNT = ckr_pkg::KEYWORD_COUNT,
  parameter int MAX_KEY_LEN   = ckr_pkg::MAX_KEY_LEN,
  parameter int HASH_MODULUS  = ckr_pkg::HASH_MODULUS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_data
);

  localparam int POS_W     = $clog2(MAX_KEY_LEN + 2);
  localparam int POS_LIMIT = MAX_KEY_LEN + 1;

  logic                compress_enable;
  logic [7:0]          text_buffer [MAX_KEY_LEN];
  logic [POS_W-1:0]    char_position;
  logic [BUCKET_W-1:0] running_bucket;

  logic [7:0]          text_next [MAX_KEY_LEN];
  logic [POS_W-1:0]    char_position_next;
  logic [BUCKET_W-1:0] running_bucket_next;
  logic [BUCKET_W:0]   bucket_sum;
  logic [BUCKET_W-1:0] byte_mod [256];
  logic [INDEX_W-1:0]  match_index;
  logic                accept;
  out_t                result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Byte value reduced by the modulus, so the running sum stays below 2*M.
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign byte_mod[i] = BUCKET_W'(i % HASH_MODULUS);
  end

  always_comb begin
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      text_next[j] = (char_position == POS_W'(j)) ? in_data.char_byte : text_buffer[j];
    end
    char_position_next = (char_position < POS_W'(POS_LIMIT)) ?
                         char_position + POS_W'(1) : char_position;
    bucket_sum = {1'b0, running_bucket} + {1'b0, byte_mod[in_data.char_byte]};
    running_bucket_next = (bucket_sum >= (BUCKET_W+1)'(HASH_MODULUS)) ?
                          BUCKET_W'(bucket_sum - (BUCKET_W+1)'(HASH_MODULUS)) :
                          bucket_sum[BUCKET_W-1:0];
  end

  ckr_match #(
    .KEYWORD_COUNT(KEYWORD_COUNT),
    .MAX_KEY_LEN  (MAX_KEY_LEN),
    .POS_W        (POS_W)
  ) u_match (
    .text       (text_next),
    .text_len   (char_position_next),
    .match_index(match_index)
  );

  always_comb begin
    result.is_keyword    = (match_index != '0);
    result.keyword_index = match_index;
    result.replace_first = compress_enable && (match_index != '0) &&
                           (match_index < SPACE_CODE);
    result.hash_bucket   = running_bucket_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compress_enable <= 1'b0;
    end else if (cfg_we) begin
      compress_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      running_bucket <= '0;
    end else if (accept) begin
      if (in_data.last_char) begin
        char_position  <= '0;
        running_bucket <= '0;
      end else begin
        char_position  <= char_position_next;
        running_bucket <= running_bucket_next;
      end
    end
  end

  // Only entries below the current count are ever compared, so no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      text_buffer <= text_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_char) begin
      out_data <= result;
    end
  end

endmodule

### src/ckr_checker.sv
// Port-level checks for the keyword recognizer, bound to the top level.
`timescale 1ns / 1ps

module ckr_checker
  import ckr_pkg::*;
#(
  parameter int HASH_MODULUS = ckr_pkg::HASH_MODULUS
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A held result stays put while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new result only follows an accepted final byte.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && out_stall) |->
      $past(in_valid && !in_stall && in_data.last_char))
    else $error("result without final byte");

  // The block only stalls requests when its result register is full and the receiver stalls.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_keyword == (out_data.keyword_index != '0)) &&
                  (!out_data.replace_first || (out_data.is_keyword &&
                   out_data.keyword_index < SPACE_CODE)) &&
                  (out_data.hash_bucket < BUCKET_W'(HASH_MODULUS)))
    else $error("inconsistent result fields");

endmodule

bind c_keyword_recognizer ckr_checker #(.HASH_MODULUS(HASH_MODULUS)) u_ckr_checker (.*);
